/* rtl/battery_level_hysteresis_monitor_core_assert.svh */
// Assertion macros for the monitor checker.
`ifndef BATTERY_LEVEL_HYSTERESIS_MONITOR_CORE_ASSERT_SVH
`define BATTERY_LEVEL_HYSTERESIS_MONITOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLHM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLHM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/blhm_pkg.sv */
// Shared types, constants and register map of the battery level monitor.
package blhm_pkg;

	localparam int ADC_W = 12;
	localparam int CV_W  = 9;
	localparam int LVL_W = 2;
	localparam int REG_W = 9;
	localparam int IDX_W = 3;

	localparam int BLOCK_SAMPLES_DEF = 16;

	// Voltage scale: centivolts = mean * SCALE_NUM / 2**SCALE_SHIFT
	localparam int SCALE_SHIFT = 12;
	localparam logic [CV_W-1:0] SCALE_NUM = 9'd450;
	localparam logic [CV_W-1:0] MAX_CV    = 9'd449;

	typedef enum logic [LVL_W-1:0] {
		LVL_HIGH    = 2'd0,
		LVL_OK      = 2'd1,
		LVL_LOW     = 2'd2,
		LVL_VERYLOW = 2'd3
	} level_t;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_HIGH_EXIT    = 3'd0;
	localparam logic [IDX_W-1:0] REG_OK_RISE      = 3'd1;
	localparam logic [IDX_W-1:0] REG_OK_FALL      = 3'd2;
	localparam logic [IDX_W-1:0] REG_LOW_RISE     = 3'd3;
	localparam logic [IDX_W-1:0] REG_LOW_FALL     = 3'd4;
	localparam logic [IDX_W-1:0] REG_VERYLOW_RISE = 3'd5;

	// Reset values in centivolts
	localparam logic [REG_W-1:0] RST_HIGH_EXIT    = 9'd380;
	localparam logic [REG_W-1:0] RST_OK_RISE      = 9'd390;
	localparam logic [REG_W-1:0] RST_OK_FALL      = 9'd340;
	localparam logic [REG_W-1:0] RST_LOW_RISE     = 9'd350;
	localparam logic [REG_W-1:0] RST_LOW_FALL     = 9'd300;
	localparam logic [REG_W-1:0] RST_VERYLOW_RISE = 9'd310;

	typedef struct packed {
		logic [REG_W-1:0] high_exit;
		logic [REG_W-1:0] ok_rise;
		logic [REG_W-1:0] ok_fall;
		logic [REG_W-1:0] low_rise;
		logic [REG_W-1:0] low_fall;
		logic [REG_W-1:0] verylow_rise;
	} thr_t;

	// Block mean handed from the accumulator to the classifier
	typedef struct packed {
		logic             valid;
		logic [ADC_W-1:0] mean;
	} mean_xfer_t;

endpackage

/* rtl/blhm_cfg.sv */
// Threshold register file of the battery level monitor.
module blhm_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [blhm_pkg::IDX_W-1:0] cfg_index,
	input  logic [blhm_pkg::REG_W-1:0] cfg_data,
	output blhm_pkg::thr_t            thr
);
	import blhm_pkg::*;

	thr_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.high_exit    <= RST_HIGH_EXIT;
			thr_q.ok_rise      <= RST_OK_RISE;
			thr_q.ok_fall      <= RST_OK_FALL;
			thr_q.low_rise     <= RST_LOW_RISE;
			thr_q.low_fall     <= RST_LOW_FALL;
			thr_q.verylow_rise <= RST_VERYLOW_RISE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIGH_EXIT:    thr_q.high_exit    <= cfg_data;
				REG_OK_RISE:      thr_q.ok_rise      <= cfg_data;
				REG_OK_FALL:      thr_q.ok_fall      <= cfg_data;
				REG_LOW_RISE:     thr_q.low_rise     <= cfg_data;
				REG_LOW_FALL:     thr_q.low_fall     <= cfg_data;
				REG_VERYLOW_RISE: thr_q.verylow_rise <= cfg_data;
				default: ;
			endcase
		end
	end

	assign thr = thr_q;

endmodule

/* rtl/blhm_accum.sv */
// Sample accumulator and block mean stage of the battery level monitor.
module blhm_accum #(
	parameter int BLOCK_SAMPLES = blhm_pkg::BLOCK_SAMPLES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic [blhm_pkg::ADC_W-1:0] adc_sample,
	output blhm_pkg::mean_xfer_t       mean_out,
	input  logic                       mean_take
);
	import blhm_pkg::*;

	localparam int CNT_W   = $clog2(BLOCK_SAMPLES);
	localparam int SUM_W   = ADC_W + CNT_W;
	// Exact floor division by reciprocal: shift K, multiplier ceil(2**K / N)
	localparam int RCP_SH  = SUM_W + CNT_W;
	localparam int RCP_W   = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RCP_W;
	localparam longint unsigned RCP_L =
		((longint'(1) << RCP_SH) + longint'(BLOCK_SAMPLES) - 1) / longint'(BLOCK_SAMPLES);
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_SAMPLES - 1);

	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_next;
	logic              blk_last;
	logic              accept;
	logic              v_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic              v_s2;
	logic [ADC_W-1:0]  mean_s2;
	logic              take_s1;
	logic              take_s2;
	logic [PROD_W-1:0] prod;

	assign sum_next = sum_q + SUM_W'(adc_sample);
	assign blk_last = (count_q == LAST_CNT);
	assign take_s2  = !v_s2 || mean_take;
	assign take_s1  = !v_s1 || take_s2;
	// Hold off only the sample that closes a block when no stage can take it
	assign sample_stall = blk_last && !take_s1;
	assign accept   = sample_valid && !sample_stall;
	assign prod     = PROD_W'(sum_s1) * PROD_W'(RCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (accept) begin
				if (blk_last) begin
					count_q <= '0;
					sum_q   <= '0;
				end else begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_next;
				end
			end
			if (take_s1)
				v_s1 <= accept && blk_last;
			if (take_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && accept && blk_last)
			sum_s1 <= sum_next;
		if (take_s2 && v_s1)
			mean_s2 <= prod[RCP_SH +: ADC_W];
	end

	assign mean_out.valid = v_s2;
	assign mean_out.mean  = mean_s2;

endmodule

/* rtl/blhm_classify.sv */
// Voltage scaling, hysteresis level update and result register.
module blhm_classify (
	input  logic                       clk,
	input  logic                       arst_n,
	input  blhm_pkg::mean_xfer_t       mean_in,
	output logic                       mean_take,
	input  blhm_pkg::thr_t             thr,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [blhm_pkg::LVL_W-1:0] battery_level,
	output logic [blhm_pkg::CV_W-1:0]  voltage_centivolts
);
	import blhm_pkg::*;

	localparam int SPROD_W = ADC_W + CV_W;

	level_t              level_q;
	level_t              level_next;
	logic                result_valid_q;
	logic [LVL_W-1:0]    battery_level_q;
	logic [CV_W-1:0]     voltage_q;
	logic [SPROD_W-1:0]  sprod;
	logic [CV_W-1:0]     volts;
	logic                load;

	assign sprod = SPROD_W'(mean_in.mean) * SPROD_W'(SCALE_NUM);
	assign volts = sprod[SCALE_SHIFT +: CV_W];

	// Downward check comes last in ok and low, so it wins when both hold
	always_comb begin
		level_next = level_q;
		unique case (level_q)
			LVL_HIGH: begin
				if (volts < thr.high_exit) level_next = LVL_OK;
			end
			LVL_OK: begin
				if (volts > thr.ok_rise) level_next = LVL_HIGH;
				if (volts < thr.ok_fall) level_next = LVL_LOW;
			end
			LVL_LOW: begin
				if (volts > thr.low_rise) level_next = LVL_OK;
				if (volts < thr.low_fall) level_next = LVL_VERYLOW;
			end
			LVL_VERYLOW: begin
				if (volts > thr.verylow_rise) level_next = LVL_LOW;
			end
			default: level_next = level_q;
		endcase
	end

	assign mean_take = !result_valid_q || !result_stall;
	assign load      = mean_in.valid && mean_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q        <= LVL_OK;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				level_q        <= level_next;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			battery_level_q <= level_next;
			voltage_q       <= volts;
		end
	end

	assign result_valid       = result_valid_q;
	assign battery_level      = battery_level_q;
	assign voltage_centivolts = voltage_q;

endmodule

/* rtl/battery_level_hysteresis_monitor_core.sv */
// Battery level monitor: takes one ADC sample per cycle on the sample channel while
// sample_stall is low and sums BLOCK_SAMPLES of them. The sample that closes a block
// reaches the result register through the sum register, loaded at the edge that
// accepts it, then the reciprocal-multiply mean stage, then the scale and hysteresis
// stage. One result per block comes out as voltage in centivolts (mean * 450 / 4096)
// with the new level (0 high, 1 ok, 2 low, 3 very low). Level starts at ok after
// reset; each block moves it by at most one step. Samples that do not close a block
// are always taken; the closing sample waits only while the result register is held
// by result_stall and both internal stages are occupied. Threshold registers 0..5
// (centivolts) are written on cfg_we and should change only while idle.
module battery_level_hysteresis_monitor_core #(
	parameter int BLOCK_SAMPLES = blhm_pkg::BLOCK_SAMPLES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic [blhm_pkg::ADC_W-1:0]  adc_sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [blhm_pkg::LVL_W-1:0]  battery_level,
	output logic [blhm_pkg::CV_W-1:0]   voltage_centivolts,
	input  logic                        cfg_we,
	input  logic [blhm_pkg::IDX_W-1:0]  cfg_index,
	input  logic [blhm_pkg::REG_W-1:0]  cfg_data
);
	import blhm_pkg::*;

	thr_t       thr;
	mean_xfer_t mean_xfer;
	logic       mean_take;

	blhm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	blhm_accum #(
		.BLOCK_SAMPLES (BLOCK_SAMPLES)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.adc_sample   (adc_sample),
		.mean_out     (mean_xfer),
		.mean_take    (mean_take)
	);

	blhm_classify u_classify (
		.clk                (clk),
		.arst_n             (arst_n),
		.mean_in            (mean_xfer),
		.mean_take          (mean_take),
		.thr                (thr),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.battery_level      (battery_level),
		.voltage_centivolts (voltage_centivolts)
	);

endmodule

/* rtl/blhm_checker.sv */
// Port-level checker for the battery level monitor, bound to the top level.
`include "battery_level_hysteresis_monitor_core_assert.svh"

module blhm_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	input  logic                        sample_stall,
	input  logic [blhm_pkg::ADC_W-1:0]  adc_sample,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  logic [blhm_pkg::LVL_W-1:0]  battery_level,
	input  logic [blhm_pkg::CV_W-1:0]   voltage_centivolts,
	input  logic                        cfg_we,
	input  logic [blhm_pkg::IDX_W-1:0]  cfg_index,
	input  logic [blhm_pkg::REG_W-1:0]  cfg_data
);
	import blhm_pkg::*;

	logic [LVL_W-1:0] last_level_q;
	logic             step_ok;
	logic             unused_ok;

	// Track the level of the last delivered transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_level_q <= LVL_OK;
		else if (result_valid && !result_stall)
			last_level_q <= battery_level;
	end

	assign step_ok = !((last_level_q == LVL_HIGH && battery_level == LVL_LOW) ||
		(last_level_q == LVL_HIGH && battery_level == LVL_VERYLOW) ||
		(last_level_q == LVL_OK && battery_level == LVL_VERYLOW) ||
		(last_level_q == LVL_LOW && battery_level == LVL_HIGH) ||
		(last_level_q == LVL_VERYLOW && battery_level == LVL_HIGH) ||
		(last_level_q == LVL_VERYLOW && battery_level == LVL_OK));

	assign unused_ok = sample_valid | (|adc_sample) | cfg_we | (|cfg_index) | (|cfg_data);

	`BLHM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(battery_level) && $stable(voltage_centivolts), "stalled result changed")
	`BLHM_ASSERT_NOW(a_stall_cause, sample_stall, result_valid && result_stall, "sample stalled while result side free")
	`BLHM_ASSERT_NOW(a_volt_range, result_valid, voltage_centivolts <= MAX_CV, "voltage above full scale")
	`BLHM_ASSERT_NOW(a_level_step, result_valid && unused_ok | result_valid, step_ok, "level moved more than one step")

endmodule

bind battery_level_hysteresis_monitor_core blhm_checker u_blhm_checker (.*);
